// ===== src/tmcw_pkg.sv =====
// Shared types and constants of the text-mode console writer.
`timescale 1ns / 1ps

package tmcw_pkg;

  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_MOVE  = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_EOL   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] BLANK_CHAR   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'd7;

  typedef enum logic [3:0] {
    ST_INIT_START,
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_FILL,
    ST_NL_FILL,
    ST_NL_ADV,
    ST_SCROLL,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_CAPTURE,
    CMD_MOVE,
    CMD_PUT,
    CMD_FILL_EOL,
    CMD_FILL_ALL,
    CMD_FILL_STEP,
    CMD_NEXT_LINE,
    CMD_READ,
    CMD_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   reset_attr;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       is_nl;
    logic       put_more;
    logic       wrap_last;
    logic       tab_more;
    logic       fill_last;
    logic       last_row;
    logic       out_busy;
  } dp_status_t;

endpackage

// ===== src/tmcw_ctrl.sv =====
// Sequencer of the console writer: decodes operations and steps the datapath.
`timescale 1ns / 1ps

module tmcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmcw_pkg::dp_status_t st,
  output tmcw_pkg::dp_cmd_t    cmd
);
  import tmcw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = CMD_NOP;
    cmd.reset_attr = 1'b0;
    in_ready       = 1'b0;
    unique case (state_r)
      ST_INIT_START: begin
        cmd.op         = CMD_FILL_ALL;
        cmd.reset_attr = 1'b1;
        state_nxt      = ST_INIT;
      end
      ST_INIT: begin
        cmd.op         = CMD_FILL_STEP;
        cmd.reset_attr = 1'b1;
        if (st.fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = CMD_CAPTURE;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (st.op)
          OP_PUT: begin
            if (st.is_nl) begin
              cmd.op    = CMD_FILL_EOL;
              state_nxt = ST_NL_FILL;
            end else begin
              state_nxt = ST_PUT;
            end
          end
          OP_MOVE: begin
            cmd.op    = CMD_MOVE;
            state_nxt = ST_DONE;
          end
          OP_CLEAR: begin
            cmd.op    = CMD_FILL_ALL;
            state_nxt = ST_FILL;
          end
          OP_EOL: begin
            cmd.op    = CMD_FILL_EOL;
            state_nxt = ST_FILL;
          end
          OP_READ: begin
            cmd.op    = CMD_READ;
            state_nxt = ST_READ_WAIT;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_PUT: begin
        cmd.op = CMD_PUT;
        if (st.wrap_last) state_nxt = ST_SCROLL;
        else if (!st.put_more) state_nxt = ST_DONE;
      end
      ST_FILL: begin
        cmd.op = CMD_FILL_STEP;
        if (st.fill_last) state_nxt = ST_DONE;
      end
      ST_NL_FILL: begin
        cmd.op = CMD_FILL_STEP;
        if (st.fill_last) state_nxt = ST_NL_ADV;
      end
      ST_NL_ADV: begin
        cmd.op    = CMD_NEXT_LINE;
        state_nxt = st.last_row ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd.op = CMD_FILL_STEP;
        if (st.fill_last) state_nxt = st.tab_more ? ST_PUT : ST_DONE;
      end
      ST_READ_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.op    = CMD_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT_START;
    endcase
  end

endmodule

// ===== src/tmcw_datapath.sv =====
// Datapath of the console writer: cell memory, row ring, cursor, fill walker, result register.
`timescale 1ns / 1ps

module tmcw_datapath #(
  parameter int NUM_ROWS = 25,
  parameter int NUM_COLS = 80,
  parameter int TAB_STOP = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmcw_pkg::dp_cmd_t    cmd,
  output tmcw_pkg::dp_status_t st,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic [2:0]           in_operation,
  input  logic [7:0]           in_char_code,
  input  logic [4:0]           in_target_row,
  input  logic [6:0]           in_target_col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [4:0]           out_cursor_row,
  output logic [6:0]           out_cursor_col,
  output logic [10:0]          out_cursor_offset,
  output logic [7:0]           out_cell_char,
  output logic [7:0]           out_cell_attr
);
  import tmcw_pkg::*;

  localparam int RW        = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CW        = $clog2(NUM_COLS);
  localparam int AW        = RW + CW;
  localparam int TCW       = $clog2(TAB_STOP + 1);
  localparam int MEM_DEPTH = NUM_ROWS * (2 ** CW);

  localparam logic [RW-1:0] ROW_LAST = RW'(NUM_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(NUM_COLS - 1);
  localparam logic [RW:0]   ROWS_W   = (RW + 1)'(NUM_ROWS);

  logic [15:0] mem [MEM_DEPTH];

  logic [2:0]     op_r;
  logic [7:0]     char_r;
  logic [4:0]     trow_r;
  logic [6:0]     tcol_r;
  logic [RW-1:0]  cur_row_r;
  logic [CW-1:0]  cur_col_r;
  logic [RW-1:0]  top_r;
  logic [7:0]     attr_r;
  logic [TCW-1:0] tab_cnt_r;
  logic [RW-1:0]  frow_r;
  logic [CW-1:0]  fcol_r;
  logic [RW-1:0]  fend_r;
  logic [15:0]    rd_data_r;
  logic           out_valid_r;
  logic [4:0]     out_row_r;
  logic [6:0]     out_col_r;
  logic [10:0]    out_off_r;
  logic [7:0]     out_char_r;
  logic [7:0]     out_attr_r;

  logic [TCW-1:0] tab_rem [NUM_COLS];
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_tab_rem
    assign tab_rem[c] = TCW'(c % TAB_STOP);
  end

  logic [RW:0]    cur_sum, t_sum;
  logic [RW-1:0]  prow, tprow, trow_idx, top_inc;
  logic [CW-1:0]  tcol_idx;
  logic [31:0]    trow_ext, tcol_ext;
  logic           t_in_range, last_col, last_row, is_tab, rd_hit;
  logic [TCW-1:0] tab_first;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [15:0]    wr_data;
  logic [7:0]     glyph, blank_attr;
  logic [AW-1:0]  offset_full;
  logic [31:0]    row_ext, col_ext, off_ext;

  always_comb begin
    cur_sum    = (RW + 1)'(cur_row_r) + (RW + 1)'(top_r);
    prow       = (cur_sum >= ROWS_W) ? RW'(cur_sum - ROWS_W) : cur_sum[RW-1:0];
    trow_ext   = 32'(trow_r);
    tcol_ext   = 32'(tcol_r);
    trow_idx   = trow_ext[RW-1:0];
    tcol_idx   = tcol_ext[CW-1:0];
    t_in_range = (trow_ext < NUM_ROWS) && (tcol_ext < NUM_COLS);
    t_sum      = (RW + 1)'(trow_idx) + (RW + 1)'(top_r);
    tprow      = (t_sum >= ROWS_W) ? RW'(t_sum - ROWS_W) : t_sum[RW-1:0];
    top_inc    = (top_r == ROW_LAST) ? '0 : top_r + 1'b1;
    last_col   = (cur_col_r == COL_LAST);
    last_row   = (cur_row_r == ROW_LAST);
    is_tab     = (op_r == OP_PUT) && (char_r == CHAR_TAB);
    rd_hit     = (op_r == OP_READ) && t_in_range;
    tab_first  = TCW'(TAB_STOP) - tab_rem[cur_col_r];
    glyph      = is_tab ? BLANK_CHAR : char_r;
    blank_attr = cmd.reset_attr ? RESET_ATTR : attr_r;

    wr_en   = 1'b0;
    wr_addr = {frow_r, fcol_r};
    wr_data = {BLANK_CHAR, blank_attr};
    if (cmd.op == CMD_PUT) begin
      wr_en   = 1'b1;
      wr_addr = {prow, cur_col_r};
      wr_data = {glyph, attr_r};
    end else if (cmd.op == CMD_FILL_STEP) begin
      wr_en = 1'b1;
    end

    offset_full = AW'(cur_row_r) * AW'(NUM_COLS) + AW'(cur_col_r);
    row_ext     = 32'(cur_row_r);
    col_ext     = 32'(cur_col_r);
    off_ext     = 32'(offset_full);

    st.op        = op_r;
    st.is_nl     = (op_r == OP_PUT) && (char_r == CHAR_NEWLINE);
    st.put_more  = is_tab && (tab_cnt_r > TCW'(1));
    st.wrap_last = last_col && last_row;
    st.tab_more  = is_tab && (tab_cnt_r != '0);
    st.fill_last = (fcol_r == COL_LAST) && (frow_r == fend_r);
    st.last_row  = last_row;
    st.out_busy  = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.op == CMD_READ) rd_data_r <= mem[{tprow, tcol_idx}];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) attr_r <= cfg_wr_data;
      if (cmd.op == CMD_RESULT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        CMD_MOVE: begin
          if (t_in_range) begin
            cur_row_r <= trow_idx;
            cur_col_r <= tcol_idx;
          end
        end
        CMD_FILL_ALL: begin
          cur_row_r <= '0;
          cur_col_r <= '0;
        end
        CMD_PUT, CMD_NEXT_LINE: begin
          if (cmd.op == CMD_NEXT_LINE || last_col) begin
            cur_col_r <= '0;
            if (last_row) top_r <= top_inc;
            else cur_row_r <= cur_row_r + 1'b1;
          end else begin
            cur_col_r <= cur_col_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_CAPTURE: begin
        op_r      <= in_operation;
        char_r    <= in_char_code;
        trow_r    <= in_target_row;
        tcol_r    <= in_target_col;
        tab_cnt_r <= tab_first;
      end
      CMD_PUT, CMD_NEXT_LINE: begin
        if (cmd.op == CMD_PUT) tab_cnt_r <= tab_cnt_r - 1'b1;
        // new bottom row is the old top row of the ring
        if ((cmd.op == CMD_NEXT_LINE || last_col) && last_row) begin
          frow_r <= top_r;
          fcol_r <= '0;
          fend_r <= top_r;
        end
      end
      CMD_FILL_EOL: begin
        frow_r <= prow;
        fcol_r <= cur_col_r;
        fend_r <= prow;
      end
      CMD_FILL_ALL: begin
        frow_r <= '0;
        fcol_r <= '0;
        fend_r <= ROW_LAST;
      end
      CMD_FILL_STEP: begin
        if (fcol_r == COL_LAST) begin
          fcol_r <= '0;
          frow_r <= frow_r + 1'b1;
        end else begin
          fcol_r <= fcol_r + 1'b1;
        end
      end
      CMD_RESULT: begin
        out_row_r  <= row_ext[4:0];
        out_col_r  <= col_ext[6:0];
        out_off_r  <= off_ext[10:0];
        out_char_r <= rd_hit ? rd_data_r[15:8] : 8'd0;
        out_attr_r <= rd_hit ? rd_data_r[7:0] : 8'd0;
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_offset = out_off_r;
  assign out_cell_char     = out_char_r;
  assign out_cell_attr     = out_attr_r;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_col_r) < NUM_COLS)
    else $error("cursor column out of range");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < NUM_ROWS)
    else $error("cursor row out of range");
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) < NUM_ROWS)
    else $error("ring top row out of range");
  a_tab_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CMD_PUT && is_tab) |-> tab_cnt_r != '0)
    else $error("tab space written with no count left");
  a_fill_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CMD_FILL_STEP) |-> 32'(frow_r) < NUM_ROWS)
    else $error("fill walker beyond last row");
`endif

endmodule

// ===== src/text_mode_console_writer_top.sv =====
// Top level of the text-mode console writer: sequencer plus datapath.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------
//   input   | in_operation, in_char_code, in_target_* | in_valid / in_ready
//   result  | out_cursor_*, out_cell_char/attr        | out_valid / out_ready
//   config  | cfg_wr_data                             | cfg_wr_en, no wait
//
// One item at a time through the sequencer; single-port cell memory writes one cell a cycle.
// A tab writes blanks up to the next tab stop; a newline blanks the rest of the line first.
// Clear to end of line blanks from the cursor column to the last column of the row.
// A scroll from put, tab or newline blanks the new bottom row; clear screen blanks every cell.
// After reset a clearing pass over all NUM_ROWS * NUM_COLS cells runs with in_ready low.
// A stalled result holds the next one in the sequencer; inputs are taken once it is free.
`timescale 1ns / 1ps

module text_mode_console_writer_top #(
  parameter int NUM_ROWS = 25,
  parameter int NUM_COLS = 80,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_target_row,
  input  logic [6:0]  in_target_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic [10:0] out_cursor_offset,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr
);
  import tmcw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  tmcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tmcw_datapath #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_operation      (in_operation),
    .in_char_code      (in_char_code),
    .in_target_row     (in_target_row),
    .in_target_col     (in_target_col),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_offset (out_cursor_offset),
    .out_cell_char     (out_cell_char),
    .out_cell_attr     (out_cell_attr)
  );

endmodule

// ===== tb/text_mode_console_writer_top_test.sv =====
// Self-checking testbench for the text-mode console writer top level.
`timescale 1ns / 1ps

module text_mode_console_writer_top_test;
  import tmcw_pkg::*;

  localparam int NUM_ROWS = 25;
  localparam int NUM_COLS = 80;
  localparam int TAB_STOP = 8;
  localparam int SCREEN_CELLS = NUM_ROWS * NUM_COLS;
  localparam logic [2:0] OP_MAX = 3'd7;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 140;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } cursor_report_t;

  class console_scoreboard;
    logic [7:0] glyph [SCREEN_CELLS];
    logic [7:0] shade [SCREEN_CELLS];
    int unsigned row;
    int unsigned col;
    logic [7:0] attr;
    cursor_report_t report_q[$];
    int errors;

    function new();
      for (int i = 0; i < SCREEN_CELLS; i++) begin
        glyph[i] = BLANK_CHAR;
        shade[i] = RESET_ATTR;
      end
      row = 0;
      col = 0;
      attr = RESET_ATTR;
      errors = 0;
    endfunction

    function void blank(int unsigned start, int unsigned count);
      for (int unsigned i = start; i < start + count; i++) begin
        if (i < SCREEN_CELLS) begin
          glyph[i] = BLANK_CHAR;
          shade[i] = attr;
        end
      end
    endfunction

    function void next_line();
      col = 0;
      if (row >= NUM_ROWS - 1) begin
        for (int i = 0; i < SCREEN_CELLS - NUM_COLS; i++) begin
          glyph[i] = glyph[i + NUM_COLS];
          shade[i] = shade[i + NUM_COLS];
        end
        blank((NUM_ROWS - 1) * NUM_COLS, NUM_COLS);
      end else begin
        row++;
      end
    endfunction

    function void put_glyph(logic [7:0] c);
      int unsigned p;
      p = row * NUM_COLS + col;
      glyph[p] = c;
      shade[p] = attr;
      col++;
      if (col >= NUM_COLS) next_line();
    endfunction

    // Predict the report for one accepted input transfer.
    function void note_input(logic [2:0] op, logic [7:0] ch, logic [4:0] tr, logic [6:0] tc);
      cursor_report_t rep;
      int unsigned n;
      rep = '0;
      case (op)
        OP_PUT: begin
          if (ch == CHAR_TAB) begin
            n = TAB_STOP - (col % TAB_STOP);
            repeat (n) put_glyph(BLANK_CHAR);
          end else if (ch == CHAR_NEWLINE) begin
            blank(row * NUM_COLS + col, NUM_COLS - col);
            next_line();
          end else begin
            put_glyph(ch);
          end
        end
        OP_MOVE: begin
          if (tr < NUM_ROWS && tc < NUM_COLS) begin
            row = 32'(tr);
            col = 32'(tc);
          end
        end
        OP_CLEAR: begin
          blank(0, SCREEN_CELLS);
          row = 0;
          col = 0;
        end
        OP_EOL: blank(row * NUM_COLS + col, NUM_COLS - col);
        OP_READ: begin
          if (tr < NUM_ROWS && tc < NUM_COLS) begin
            rep.cell_char = glyph[tr * NUM_COLS + tc];
            rep.cell_attr = shade[tr * NUM_COLS + tc];
          end
        end
        default: ;
      endcase
      rep.cursor_row = row[4:0];
      rep.cursor_col = col[6:0];
      rep.cursor_offset = 11'(row * NUM_COLS + col);
      report_q.push_back(rep);
    endfunction

    function void check_result(cursor_report_t got);
      cursor_report_t exp_rep;
      if (report_q.size() == 0) begin
        $error("result transfer with no input pending");
        errors++;
        return;
      end
      exp_rep = report_q.pop_front();
      if (got.cursor_row !== exp_rep.cursor_row) begin
        $error("cursor_row: expected %0d, actual %0d", exp_rep.cursor_row, got.cursor_row);
        errors++;
      end
      if (got.cursor_col !== exp_rep.cursor_col) begin
        $error("cursor_col: expected %0d, actual %0d", exp_rep.cursor_col, got.cursor_col);
        errors++;
      end
      if (got.cursor_offset !== exp_rep.cursor_offset) begin
        $error("cursor_offset: expected %0d, actual %0d",
               exp_rep.cursor_offset, got.cursor_offset);
        errors++;
      end
      if (got.cell_char !== exp_rep.cell_char) begin
        $error("cell_char: expected %0d, actual %0d", exp_rep.cell_char, got.cell_char);
        errors++;
      end
      if (got.cell_attr !== exp_rep.cell_attr) begin
        $error("cell_attr: expected %0d, actual %0d", exp_rep.cell_attr, got.cell_attr);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = '0;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_target_row = '0;
  logic [6:0]  in_target_col = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_col;
  logic [10:0] out_cursor_offset;
  logic [7:0]  out_cell_char;
  logic [7:0]  out_cell_attr;

  logic        gaps_on = 1'b1;
  int unsigned quiet_cycles = 0;
  console_scoreboard sb = new();

  text_mode_console_writer_top #(
    .NUM_ROWS(NUM_ROWS),
    .NUM_COLS(NUM_COLS),
    .TAB_STOP(TAB_STOP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_char_code(in_char_code),
    .in_target_row(in_target_row),
    .in_target_col(in_target_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_cursor_offset(out_cursor_offset),
    .out_cell_char(out_cell_char),
    .out_cell_attr(out_cell_attr)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_operation, in_char_code, in_target_row, in_target_col);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_cursor_row, out_cursor_col, out_cursor_offset,
                       out_cell_char, out_cell_attr});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic send_item(logic [2:0] op, logic [7:0] ch, logic [4:0] tr, logic [6:0] tc);
    int gap;
    gap = 0;
    if (gaps_on) while ($urandom_range(0, 99) < 7) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_char_code <= ch;
    in_target_row <= tr;
    in_target_col <= tc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the monitor note a transfer taken at the current edge before checking the queue
    @(posedge clk);
    while (sb.report_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_attribute(logic [7:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.attr = value;
  endtask

  task automatic send_random_item();
    int pick;
    int r;
    logic [2:0] op;
    logic [7:0] ch;
    logic [4:0] tr;
    logic [6:0] tc;
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    ch = 8'($urandom_range(0, 255));
    tr = 5'($urandom_range(0, 31));
    tc = 7'($urandom_range(0, 127));
    if (pick < 55) begin
      op = OP_PUT;
      if (r < 10) ch = CHAR_TAB;
      else if (r < 20) ch = CHAR_NEWLINE;
    end else if (pick < 67) begin
      op = OP_MOVE;
      if (r < 60) begin
        tr = 5'($urandom_range(NUM_ROWS - 3, NUM_ROWS - 1));
        tc = 7'($urandom_range(0, NUM_COLS - 1));
      end else if (r < 85) begin
        tr = 5'($urandom_range(0, NUM_ROWS - 1));
        tc = 7'($urandom_range(0, NUM_COLS - 1));
      end
    end else if (pick < 68) begin
      op = OP_CLEAR;
    end else if (pick < 75) begin
      op = OP_EOL;
    end else if (pick < 96) begin
      op = OP_READ;
      if (r < 50) begin
        tr = sb.row[4:0];
        tc = 7'($urandom_range(0, NUM_COLS - 1));
      end else if (r < 80) begin
        tr = 5'($urandom_range(0, NUM_ROWS - 1));
        tc = 7'($urandom_range(0, NUM_COLS - 1));
      end
    end else begin
      op = 3'($urandom_range(OP_READ + 1, OP_MAX));
    end
    send_item(op, ch, tr, tc);
  endtask

  initial begin
    logic [7:0] phase_attr [PHASES];
    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'($urandom_range(1, 254));
    phase_attr[2] = 8'hFF;
    phase_attr[3] = 8'($urandom_range(0, 255));
    phase_attr[4] = RESET_ATTR;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, range edges, wrap, tab, newline, scroll, clear, unused codes
    send_item(OP_READ, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'hFF, 5'(NUM_ROWS - 1), 7'(NUM_COLS - 1));
    send_item(OP_READ, 8'h00, 5'd31, 7'd127);
    send_item(OP_READ, 8'h00, 5'(NUM_ROWS), 7'd0);
    send_item(OP_READ, 8'h00, 5'd0, 7'(NUM_COLS));
    send_item(OP_PUT, 8'h41, 5'd31, 7'd127);
    send_item(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_item(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_item(OP_PUT, CHAR_TAB, 5'd0, 7'd0);
    send_item(OP_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
    send_item(OP_MOVE, 8'h00, 5'(NUM_ROWS - 1), 7'(NUM_COLS - 2));
    send_item(OP_PUT, 8'h78, 5'd0, 7'd0);
    send_item(OP_PUT, 8'h79, 5'd0, 7'd0);
    send_item(OP_MOVE, 8'h00, 5'd31, 7'd127);
    send_item(OP_MOVE, 8'h00, 5'(NUM_ROWS), 7'd0);
    send_item(OP_MOVE, 8'h00, 5'd0, 7'(NUM_COLS));
    send_item(OP_READ, 8'h00, 5'(NUM_ROWS - 2), 7'(NUM_COLS - 2));
    send_item(OP_MOVE, 8'h00, 5'(NUM_ROWS - 2), 7'd5);
    send_item(OP_EOL, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ + 3'd1, 8'hAA, 5'd21, 7'd85);
    send_item(OP_MAX - 3'd1, 8'h55, 5'd10, 7'd42);
    send_item(OP_MAX, 8'hFF, 5'd31, 7'd127);
    send_item(OP_MOVE, 8'h00, 5'(NUM_ROWS - 1), 7'(NUM_COLS - TAB_STOP));
    send_item(OP_PUT, CHAR_TAB, 5'd0, 7'd0);
    send_item(OP_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'(NUM_ROWS - 2), 7'(NUM_COLS - 1));
    send_item(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_item(OP_READ, 8'h00, 5'(NUM_ROWS - 2), 7'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      load_attribute(phase_attr[ph]);
      gaps_on <= (ph != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.report_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
